// ----- rtl/core/abrd_pkg.sv -----
// Shared types and constants of the amplitude band run detector.
// Holds the register map, the event record and the output queue sizing.
// No dependencies.
package abrd_pkg;

  localparam int MAX_BANDS   = 3;
  localparam int BAND_W      = 2;
  localparam int LIMIT_W     = 16;
  localparam int MAG_W       = 17;
  localparam int SAMPLE_W    = 16;
  localparam int THRESH_W    = 24;
  localparam int FIELD_W     = 32;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 96;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = 2;
  localparam int FIFO_CW     = 3;

  localparam logic [REG_IDX_W-1:0] REG_BAND0_LOW  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BAND0_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BAND1_LOW  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BAND1_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BAND2_LOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BAND2_HIGH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GAP_LIMIT  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MIN_CHUNK  = 3'd7;

  typedef struct packed {
    logic [BAND_W-1:0]  band;
    logic [FIELD_W-1:0] start_index;
    logic [FIELD_W-1:0] run_length;
    logic [FIELD_W-1:0] event_number;
    logic               last;
  } abrd_event_t;

endpackage

// ----- rtl/core/abrd_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters. No dependencies.
module abrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/amplitude_band_run_detector.sv -----
// Top level of the amplitude band run detector.
// Depends on abrd_pkg for the register map and event record, and on abrd_ram for band state.
//
// Samples enter on the s_axis channel, one signed 16-bit sample per transaction.
// Each band's run state (open flag, start index, last in-band index) lives in a
// small RAM with one entry per band. A sample visits the bands in ascending order,
// one band per cycle while the output queue has room: the entry is read in one
// cycle and updated and written back in the next. The next sample is accepted
// while the last band of the current one is being read, but its first band is not
// read while the last band of the previous sample is being updated. That pause
// keeps reads of an entry clear of its pending write and lets the final event of
// a sample leave with its last flag. Events leave on the m_axis channel from a
// four-entry queue. When the receiver stalls, the queue fills and the band
// sequencer stops before it could overflow, which in turn holds s_axis_tready
// low. The cfg channel is always ready and writes one register per transaction.
// Reset clears the sample and event counters, all band states, all registers and
// the queue; the block accepts samples from the first cycle after reset.
module amplitude_band_run_detector #(
  parameter int COUNT_WIDTH = 32,
  parameter int NUM_BANDS   = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // sample [15:0]
  input  logic [abrd_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // start_index [31:0], run_length [63:32], event_number [95:64]
  output logic [abrd_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  // band [1:0]
  output logic [abrd_pkg::BAND_W-1:0]        m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [abrd_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [abrd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import abrd_pkg::*;

  localparam int BW     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CW     = COUNT_WIDTH;
  localparam int CMPW   = (CW > THRESH_W) ? CW : THRESH_W;
  localparam int ENT_W  = 2 * CW + 1;

  // Configuration registers.
  logic [LIMIT_W-1:0]  band_lo [MAX_BANDS];
  logic [LIMIT_W-1:0]  band_hi [MAX_BANDS];
  logic [THRESH_W-1:0] gap_limit;
  logic [THRESH_W-1:0] min_chunk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BANDS; i++) begin
        band_lo[i] <= '0;
        band_hi[i] <= '0;
      end
      gap_limit <= '0;
      min_chunk <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAND0_LOW:  band_lo[0] <= cfg_data[LIMIT_W-1:0];
        REG_BAND0_HIGH: band_hi[0] <= cfg_data[LIMIT_W-1:0];
        REG_BAND1_LOW:  band_lo[1] <= cfg_data[LIMIT_W-1:0];
        REG_BAND1_HIGH: band_hi[1] <= cfg_data[LIMIT_W-1:0];
        REG_BAND2_LOW:  band_lo[2] <= cfg_data[LIMIT_W-1:0];
        REG_BAND2_HIGH: band_hi[2] <= cfg_data[LIMIT_W-1:0];
        REG_GAP_LIMIT:  gap_limit  <= cfg_data;
        REG_MIN_CHUNK:  min_chunk  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read stage: holds the current sample and walks the bands.
  logic          a_valid;
  logic [MAG_W-1:0] a_mag;
  logic [CW-1:0] a_now;
  logic [BW-1:0] a_band;
  logic          a_issue;
  logic          a_done;
  logic [CW-1:0] sample_index;
  logic [MAG_W-1:0] in_mag;
  logic [SAMPLE_W-1:0] raw;

  // Update stage.
  logic          b_valid;
  logic [MAG_W-1:0] b_mag;
  logic [CW-1:0] b_now;
  logic [BW-1:0] b_band;
  logic          b_final;

  // Pending event and output queue.
  logic          pend_valid;
  logic          pend_last;
  abrd_event_t   pend_ev;
  abrd_event_t   fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;
  logic          push;
  logic          pop;
  abrd_event_t   push_ev;
  logic          credit_ok;

  assign raw    = s_axis_tdata[SAMPLE_W-1:0];
  assign in_mag = raw[SAMPLE_W-1] ? (MAG_W'(17'h10000) - {1'b0, raw}) : {1'b0, raw};

  assign credit_ok = (fifo_count + FIFO_CW'(pend_valid) + FIFO_CW'(b_valid)
                      + FIFO_CW'(1)) <= FIFO_CW'(FIFO_DEPTH);
  assign a_issue   = a_valid && !(b_valid && b_final) && credit_ok;
  assign a_done    = a_issue && (a_band == BW'(NUM_BANDS - 1));
  assign s_axis_tready = !a_valid || a_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      a_band       <= '0;
      sample_index <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        a_valid      <= 1'b1;
        a_band       <= '0;
        sample_index <= sample_index + CW'(1);
      end else if (a_done) begin
        a_valid <= 1'b0;
        a_band  <= '0;
      end else if (a_issue) begin
        a_band <= a_band + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      a_mag <= in_mag;
      a_now <= sample_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (a_issue) begin
      b_mag   <= a_mag;
      b_now   <= a_now;
      b_band  <= a_band;
      b_final <= (a_band == BW'(NUM_BANDS - 1));
    end
  end

  // Band state memory.
  logic [ENT_W-1:0] rd_data;
  logic [ENT_W-1:0] wr_data;
  logic [NUM_BANDS-1:0] ent_valid;

  abrd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BANDS)
  ) u_band_ram (
    .clk   (clk),
    .we    (b_valid),
    .waddr (b_band),
    .wdata (wr_data),
    .re    (a_issue),
    .raddr (a_band),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (b_valid) begin
      ent_valid[b_band] <= 1'b1;
    end
  end

  // Band update logic.
  logic [ENT_W-1:0]   ent;
  logic               cur_active;
  logic [CW-1:0]      cur_start;
  logic [CW-1:0]      cur_last_in;
  logic [LIMIT_W-1:0] lo;
  logic [LIMIT_W-1:0] hi;
  logic               in_band;
  logic [CW-1:0]      gap;
  logic [CW-1:0]      since;
  logic               close_run;
  logic               emit;
  logic [CW-1:0]      event_count;
  abrd_event_t        new_ev;

  assign ent         = ent_valid[b_band] ? rd_data : '0;
  assign cur_active  = ent[ENT_W-1];
  assign cur_start   = ent[2*CW-1:CW];
  assign cur_last_in = ent[CW-1:0];
  assign lo          = band_lo[BAND_W'(b_band)];
  assign hi          = band_hi[BAND_W'(b_band)];
  assign in_band     = (MAG_W'(lo) <= b_mag) && (b_mag <= MAG_W'(hi));
  assign gap         = b_now - cur_last_in;
  assign since       = b_now - cur_start;
  assign close_run   = !in_band && cur_active
                       && ((lo == '0) || (CMPW'(gap) > CMPW'(gap_limit)));
  assign emit        = close_run && (CMPW'(since) >= CMPW'(min_chunk));

  always_comb begin
    if (in_band) begin
      wr_data = {1'b1, (cur_active ? cur_start : b_now), b_now};
    end else if (close_run) begin
      wr_data = {1'b0, cur_start, cur_last_in};
    end else begin
      wr_data = ent;
    end
  end

  always_comb begin
    new_ev.band         = BAND_W'(b_band);
    new_ev.start_index  = FIELD_W'(cur_start);
    new_ev.run_length   = FIELD_W'(cur_last_in - cur_start);
    new_ev.event_number = FIELD_W'(event_count);
    new_ev.last         = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
    end else if (b_valid && emit) begin
      event_count <= event_count + CW'(1);
    end
  end

  // The newest event waits in a holding register until it is known whether
  // a later band of the same sample adds another event.
  always_comb begin
    push    = 1'b0;
    push_ev = pend_ev;
    if (pend_valid && pend_last) begin
      push         = 1'b1;
      push_ev.last = 1'b1;
    end else if (b_valid && emit && pend_valid) begin
      push         = 1'b1;
      push_ev.last = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      if (pend_valid && pend_last) begin
        pend_valid <= 1'b0;
        pend_last  <= 1'b0;
      end
      if (b_valid) begin
        if (emit) begin
          pend_valid <= 1'b1;
        end
        if (b_final && (emit || pend_valid)) begin
          pend_last <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && emit) begin
      pend_ev <= new_ev;
    end
  end

  assign pop = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(push) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_ev;
    end
  end

  abrd_event_t head_ev;

  assign head_ev       = fifo_mem[rd_ptr];
  assign m_axis_tvalid = (fifo_count != '0);
  assign m_axis_tdata  = {head_ev.event_number, head_ev.run_length, head_ev.start_index};
  assign m_axis_tuser  = head_ev.band;
  assign m_axis_tlast  = head_ev.last;

endmodule
